FILE: hdl/c8x_pkg.sv
// Shared types and constants for the CHIP-8 execute unit.
// Used by c8x_ctrl, c8x_dpath and chip8_instruction_execute_unit; no dependencies.
package c8x_pkg;

	typedef enum logic [1:0] {
		FN_EXEC = 2'd0,
		FN_MEMW = 2'd1,
		FN_TICK = 2'd2,
		FN_PIX  = 2'd3
	} func_t;

	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEK  = 4'h3;
	localparam logic [3:0] OP_SNEK = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDK  = 4'h6;
	localparam logic [3:0] OP_ADDK = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [3:0] ALU_LD  = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;

	localparam logic [7:0] MI_LD_VDT = 8'h07;
	localparam logic [7:0] MI_LD_DT  = 8'h15;
	localparam logic [7:0] MI_LD_ST  = 8'h18;
	localparam logic [7:0] MI_ADD_I  = 8'h1E;

	localparam logic [3:0]  REG_VF   = 4'hF;
	localparam logic [11:0] PC_RESET = 12'h200;

	typedef struct packed {
		logic capture;
		logic exec;
		logic flag_wr;
		logic div_step;
		logic fb_pix;
		logic pix_bit;
		logic drw_wr;
		logic drw_vf;
	} cmd_t;

	typedef struct packed {
		logic is_pix;
		logic pix_oob;
		logic is_drw;
		logic n_zero;
		logic need_flag;
		logic row_last;
	} sts_t;

endpackage

FILE: hdl/chip8_instruction_execute_unit.sv
// CHIP-8 execute unit. A request is taken when start is high and busy is low; done strobes
// after read and execute steps for most items and out-of-range pixel reads; flag-setting
// ALU ops add a flag write, DRW memory and framebuffer row reads then a row write per sprite
// row plus a VF write, and pixel reads row, column, row read and bit steps. busy falls the
// cycle after done and no request is taken while busy; the receiver cannot stall. Reset
// clears registers, timers, stack level and the framebuffer at once; PC resets to 0x200.
module chip8_instruction_execute_unit #(
	parameter int MEM_DEPTH     = 4096,
	parameter int STACK_DEPTH   = 16,
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [15:0] instruction,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  mem_data,
	input  logic [7:0]  random_byte,
	output logic        done,
	output logic [11:0] next_pc,
	output logic [11:0] index_value,
	output logic        pixel_value,
	output logic        screen_changed,
	output logic        collision,
	output logic        sound_on,
	output logic        unhandled
);

	c8x_pkg::cmd_t cmd;
	c8x_pkg::sts_t sts;

	c8x_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	c8x_dpath #(
		.MEM_DEPTH     (MEM_DEPTH),
		.STACK_DEPTH   (STACK_DEPTH),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (func),
		.instruction    (instruction),
		.mem_addr       (mem_addr),
		.mem_data       (mem_data),
		.random_byte    (random_byte),
		.next_pc        (next_pc),
		.index_value    (index_value),
		.pixel_value    (pixel_value),
		.screen_changed (screen_changed),
		.collision      (collision),
		.sound_on       (sound_on),
		.unhandled      (unhandled)
	);

endmodule

FILE: hdl/c8x_ctrl.sv
// Sequencing state machine for the CHIP-8 execute unit.
// Depends on c8x_pkg for the command and status structures.
module c8x_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	input  c8x_pkg::sts_t sts,
	output c8x_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_READ = 11'b000_0000_0010,
		S_EXEC = 11'b000_0000_0100,
		S_FLAG = 11'b000_0000_1000,
		S_DIV  = 11'b000_0001_0000,
		S_PRD  = 11'b000_0010_0000,
		S_PBIT = 11'b000_0100_0000,
		S_DRD  = 11'b000_1000_0000,
		S_DWR  = 11'b001_0000_0000,
		S_DVF  = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_n;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		state_n = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = start;
				if (start) state_n = S_READ;
			end
			S_READ: state_n = S_EXEC;
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.is_pix) begin
					state_n = sts.pix_oob ? S_DONE : S_DIV;
				end else if (sts.is_drw) begin
					state_n = sts.n_zero ? S_DVF : S_DRD;
				end else if (sts.need_flag) begin
					state_n = S_FLAG;
				end else begin
					state_n = S_DONE;
				end
			end
			S_FLAG: begin
				cmd.flag_wr = 1'b1;
				state_n = S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_n = S_PRD;
			end
			S_PRD: begin
				cmd.fb_pix = 1'b1;
				state_n = S_PBIT;
			end
			S_PBIT: begin
				cmd.pix_bit = 1'b1;
				state_n = S_DONE;
			end
			S_DRD: state_n = S_DWR;
			S_DWR: begin
				cmd.drw_wr = 1'b1;
				state_n = sts.row_last ? S_DVF : S_DRD;
			end
			S_DVF: begin
				cmd.drw_vf = 1'b1;
				state_n = S_DONE;
			end
			S_DONE: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

`ifndef SYNTH
	// An accepted request always leaves the idle state on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but unit not busy");
	// The result strobe lasts one cycle and the unit is free straight after it.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("unit still busy after result");
	// Operands are only captured while the unit is free.
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !busy)
		else $error("capture while busy");
	// A sprite row write is always preceded by its read cycle.
	a_drw_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drw_wr |-> ($past(state_q) == S_DRD))
		else $error("sprite row written without read");
`endif

endmodule

FILE: hdl/c8x_dpath.sv
// Datapath of the CHIP-8 execute unit: registers, stack, timers, memory, framebuffer.
// Depends on c8x_pkg; driven by c8x_ctrl through cmd_t and reports through sts_t.
module c8x_dpath #(
	parameter int MEM_DEPTH     = 4096,
	parameter int STACK_DEPTH   = 16,
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  c8x_pkg::cmd_t cmd,
	output c8x_pkg::sts_t sts,
	input  logic [1:0]    func,
	input  logic [15:0]   instruction,
	input  logic [11:0]   mem_addr,
	input  logic [7:0]    mem_data,
	input  logic [7:0]    random_byte,
	output logic [11:0]   next_pc,
	output logic [11:0]   index_value,
	output logic          pixel_value,
	output logic          screen_changed,
	output logic          collision,
	output logic          sound_on,
	output logic          unhandled
);

	localparam int AW       = $clog2(MEM_DEPTH);
	localparam int SW       = $clog2(STACK_DEPTH);
	localparam int XW       = $clog2(SCREEN_WIDTH);
	localparam int YW       = $clog2(SCREEN_HEIGHT);
	localparam int PIXELS   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int DQ_SHIFT = 12 + XW;
	localparam int DQ_MUL   = ((1 << DQ_SHIFT) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
	localparam logic [SW:0] STK_FULL = (SW + 1)'(STACK_DEPTH);

	// Captured request.
	c8x_pkg::func_t func_q;
	logic [15:0] op_q;
	logic [11:0] addr_q;
	logic [7:0]  data_q;
	logic [7:0]  rnd_q;

	// Architectural state.
	logic [11:0] pc_q, i_q;
	logic [7:0]  dt_q, st_q;
	logic [SW:0] lvl_q;
	logic [11:0] stk_q [STACK_DEPTH];

	// Result flags.
	logic pix_q, chg_q, col_q, bad_q, hit_q, flag_q;

	// Drawing and pixel-read working registers.
	logic [3:0]    row_q;
	logic [XW-1:0] xm_q;
	logic [YW-1:0] py_q;
	logic [XW-1:0] rem_q;
	logic [YW-1:0] quo_q;

	// Register file with registered read ports.
	logic [7:0]  rf_mem [16];
	logic [15:0] rf_vld_q;
	logic [7:0]  vx_raw_q, vy_raw_q;
	logic        vx_ok_q, vy_ok_q;
	logic [3:0]  ra, rb;
	logic [7:0]  vx, vy;
	logic        rf_we;
	logic [3:0]  rf_wa;
	logic [7:0]  rf_wd;

	// Main memory and framebuffer rows.
	logic [7:0]              mem [MEM_DEPTH];
	logic [7:0]              mem_rd_q;
	logic                    mem_we;
	logic [AW-1:0]           mem_ra;
	logic [SCREEN_WIDTH-1:0] fb_mem [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] fb_vld_q;
	logic [SCREEN_WIDTH-1:0] fb_row_q;
	logic                    fb_ok_q;
	logic [YW-1:0]           fb_ra;

	// Decode.
	logic [3:0]  hi, rx, ry, n;
	logic [7:0]  kk;
	logic [11:0] nnn;
	logic [11:0] pc_p2, pc_p4;
	logic [8:0]  sum9;

	// Execute results.
	logic [11:0] pc_n, i_n;
	logic [7:0]  dt_n, st_n;
	logic        bad, chg, cls, push, pop, flag_n;

	// Sprite row merge.
	logic [SCREEN_WIDTH-1:0] old_row, mask, new_row;
	logic [XW:0]             pos [8];

	// Pixel index split into row and column.
	logic [24:0] dq_prod;

	function automatic logic [7:0] byte_mod(input logic [7:0] v, input logic [7:0] d);
		logic [12:0] r;
		logic [12:0] s;
		r = {5'b0, v};
		for (int b = 4; b >= 0; b--) begin
			s = {5'b0, d} << b;
			if (r >= s) r = r - s;
		end
		return r[7:0];
	endfunction

	function automatic logic [AW-1:0] mem_wrap(input logic [11:0] v);
		logic [15:0] r;
		logic [15:0] s;
		r = {4'b0, v};
		for (int b = 2; b >= 0; b--) begin
			s = 16'(MEM_DEPTH) << b;
			if (r >= s) r = r - s;
		end
		return r[AW-1:0];
	endfunction

	assign hi  = op_q[15:12];
	assign rx  = op_q[11:8];
	assign ry  = op_q[7:4];
	assign n   = op_q[3:0];
	assign kk  = op_q[7:0];
	assign nnn = op_q[11:0];

	assign pc_p2 = pc_q + 12'd2;
	assign pc_p4 = pc_q + 12'd4;

	// JP V0 reads V0 through the second port.
	assign ra = rx;
	assign rb = (hi == c8x_pkg::OP_JPV0) ? 4'h0 : ry;
	assign vx = vx_ok_q ? vx_raw_q : 8'h00;
	assign vy = vy_ok_q ? vy_raw_q : 8'h00;
	assign sum9 = {1'b0, vx} + {1'b0, vy};

	always_comb begin
		pc_n   = pc_q;
		i_n    = i_q;
		dt_n   = dt_q;
		st_n   = st_q;
		bad    = 1'b0;
		chg    = 1'b0;
		cls    = 1'b0;
		push   = 1'b0;
		pop    = 1'b0;
		flag_n = 1'b0;
		rf_we  = 1'b0;
		rf_wa  = rx;
		rf_wd  = 8'h00;
		mem_we = 1'b0;
		if (cmd.exec) begin
			case (func_q)
				c8x_pkg::FN_MEMW: mem_we = 1'b1;
				c8x_pkg::FN_TICK: begin
					if (dt_q != 8'h00) dt_n = dt_q - 8'd1;
					if (st_q != 8'h00) st_n = st_q - 8'd1;
				end
				c8x_pkg::FN_EXEC: begin
					pc_n = pc_p2;
					case (hi)
						c8x_pkg::OP_SYS: begin
							if (op_q == c8x_pkg::OP_CLS) begin
								cls = 1'b1;
								chg = 1'b1;
							end else if (op_q == c8x_pkg::OP_RET) begin
								if (lvl_q == '0) begin
									bad = 1'b1;
								end else begin
									pop  = 1'b1;
									pc_n = stk_q[SW'(lvl_q - (SW + 1)'(1))];
								end
							end else begin
								bad = 1'b1;
							end
						end
						c8x_pkg::OP_JP: pc_n = nnn;
						c8x_pkg::OP_CALL: begin
							if (lvl_q >= STK_FULL) begin
								bad = 1'b1;
							end else begin
								push = 1'b1;
								pc_n = nnn;
							end
						end
						c8x_pkg::OP_SEK:  if (vx == kk) pc_n = pc_p4;
						c8x_pkg::OP_SNEK: if (vx != kk) pc_n = pc_p4;
						c8x_pkg::OP_SER: begin
							if (n != 4'h0) bad = 1'b1;
							else if (vx == vy) pc_n = pc_p4;
						end
						c8x_pkg::OP_SNER: begin
							if (n != 4'h0) bad = 1'b1;
							else if (vx != vy) pc_n = pc_p4;
						end
						c8x_pkg::OP_LDK: begin
							rf_we = 1'b1;
							rf_wd = kk;
						end
						c8x_pkg::OP_ADDK: begin
							rf_we = 1'b1;
							rf_wd = vx + kk;
						end
						c8x_pkg::OP_ALU: begin
							rf_we = 1'b1;
							case (n)
								c8x_pkg::ALU_LD:  rf_wd = vy;
								c8x_pkg::ALU_OR:  rf_wd = vx | vy;
								c8x_pkg::ALU_AND: rf_wd = vx & vy;
								c8x_pkg::ALU_XOR: rf_wd = vx ^ vy;
								c8x_pkg::ALU_ADD: begin
									rf_wd  = sum9[7:0];
									flag_n = sum9[8];
								end
								c8x_pkg::ALU_SUB: begin
									rf_wd  = vx - vy;
									flag_n = (vx >= vy);
								end
								c8x_pkg::ALU_SHR: begin
									rf_wd  = {1'b0, vx[7:1]};
									flag_n = vx[0];
								end
								default: begin
									rf_we = 1'b0;
									bad   = 1'b1;
								end
							endcase
						end
						c8x_pkg::OP_LDI:  i_n = nnn;
						c8x_pkg::OP_JPV0: pc_n = nnn + {4'h0, vy};
						c8x_pkg::OP_RND: begin
							rf_we = 1'b1;
							rf_wd = rnd_q & kk;
						end
						c8x_pkg::OP_DRW: chg = 1'b1;
						c8x_pkg::OP_MISC: begin
							case (kk)
								c8x_pkg::MI_LD_VDT: begin
									rf_we = 1'b1;
									rf_wd = dt_q;
								end
								c8x_pkg::MI_LD_DT: dt_n = vx;
								c8x_pkg::MI_LD_ST: st_n = vx;
								c8x_pkg::MI_ADD_I: i_n = i_q + {4'h0, vx};
								default: bad = 1'b1;
							endcase
						end
						default: bad = 1'b1;
					endcase
				end
				default: ;
			endcase
		end else if (cmd.flag_wr) begin
			rf_we = 1'b1;
			rf_wa = c8x_pkg::REG_VF;
			rf_wd = {7'b0, flag_q};
		end else if (cmd.drw_vf) begin
			rf_we = 1'b1;
			rf_wa = c8x_pkg::REG_VF;
			rf_wd = {7'b0, hit_q};
		end
	end

	// Sprite byte spread across the row with horizontal wrap.
	always_comb begin
		old_row = fb_ok_q ? fb_row_q : '0;
		mask    = '0;
		for (int c = 0; c < 8; c++) begin
			pos[c] = {1'b0, xm_q} + (XW + 1)'(c);
			if (pos[c] >= (XW + 1)'(SCREEN_WIDTH)) pos[c] = pos[c] - (XW + 1)'(SCREEN_WIDTH);
			if (mem_rd_q[7 - c]) mask[pos[c][XW-1:0]] = 1'b1;
		end
		new_row = old_row ^ mask;
	end

	// The reciprocal is rounded up far enough to give the exact row for any 12-bit index.
	assign dq_prod = {13'b0, addr_q} * 25'(DQ_MUL);
	assign mem_ra  = mem_wrap(i_q + {8'h00, row_q});
	assign fb_ra   = cmd.fb_pix ? quo_q : py_q;

	assign sts.is_pix    = (func_q == c8x_pkg::FN_PIX);
	assign sts.pix_oob   = (32'(addr_q) >= PIXELS);
	assign sts.is_drw    = (func_q == c8x_pkg::FN_EXEC) && (hi == c8x_pkg::OP_DRW);
	assign sts.n_zero    = (n == 4'h0);
	assign sts.need_flag = (func_q == c8x_pkg::FN_EXEC) && (hi == c8x_pkg::OP_ALU)
		&& ((n == c8x_pkg::ALU_ADD) || (n == c8x_pkg::ALU_SUB) || (n == c8x_pkg::ALU_SHR));
	assign sts.row_last  = (row_q == n - 4'd1);

	// Request capture; payload only.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= c8x_pkg::func_t'(func);
			op_q   <= instruction;
			addr_q <= mem_addr;
			data_q <= mem_data;
			rnd_q  <= random_byte;
		end
	end

	// Register file storage and read ports.
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		vx_raw_q <= rf_mem[ra];
		vy_raw_q <= rf_mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			vx_ok_q  <= 1'b0;
			vy_ok_q  <= 1'b0;
		end else begin
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
			vx_ok_q <= rf_vld_q[ra];
			vy_ok_q <= rf_vld_q[rb];
		end
	end

	// Main memory.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wrap(addr_q)] <= data_q;
		mem_rd_q <= mem[mem_ra];
	end

	// Framebuffer rows; a row whose valid bit is clear reads as dark.
	always_ff @(posedge clk) begin
		if (cmd.drw_wr) fb_mem[py_q] <= new_row;
		fb_row_q <= fb_mem[fb_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_vld_q <= '0;
			fb_ok_q  <= 1'b0;
		end else begin
			if (cls) fb_vld_q <= '0;
			else if (cmd.drw_wr) fb_vld_q[py_q] <= 1'b1;
			fb_ok_q <= fb_vld_q[fb_ra];
		end
	end

	// Return stack; entries are only read after being pushed.
	always_ff @(posedge clk) begin
		if (push) stk_q[lvl_q[SW-1:0]] <= pc_p2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= c8x_pkg::PC_RESET;
			i_q    <= '0;
			dt_q   <= '0;
			st_q   <= '0;
			lvl_q  <= '0;
			pix_q  <= 1'b0;
			chg_q  <= 1'b0;
			col_q  <= 1'b0;
			bad_q  <= 1'b0;
			hit_q  <= 1'b0;
			flag_q <= 1'b0;
			row_q  <= '0;
		end else begin
			pc_q <= pc_n;
			i_q  <= i_n;
			dt_q <= dt_n;
			st_q <= st_n;
			if (push) lvl_q <= lvl_q + (SW + 1)'(1);
			else if (pop) lvl_q <= lvl_q - (SW + 1)'(1);
			if (cmd.capture) begin
				pix_q <= 1'b0;
				chg_q <= 1'b0;
				col_q <= 1'b0;
				bad_q <= 1'b0;
				hit_q <= 1'b0;
				row_q <= '0;
			end
			if (cmd.exec) begin
				bad_q  <= bad;
				chg_q  <= chg;
				flag_q <= flag_n;
			end
			if (cmd.drw_wr) begin
				hit_q <= hit_q | (|(old_row & mask));
				row_q <= row_q + 4'd1;
			end
			if (cmd.drw_vf) col_q <= hit_q;
			if (cmd.pix_bit) pix_q <= fb_ok_q & fb_row_q[rem_q];
		end
	end

	// Working registers for drawing and pixel lookup.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			xm_q  <= XW'(byte_mod(vx, 8'(SCREEN_WIDTH)));
			py_q  <= YW'(byte_mod(vy, 8'(SCREEN_HEIGHT)));
			quo_q <= dq_prod[DQ_SHIFT +: YW];
		end
		if (cmd.drw_wr) begin
			if ((YW + 1)'(py_q) + (YW + 1)'(1) == (YW + 1)'(SCREEN_HEIGHT)) py_q <= '0;
			else py_q <= py_q + YW'(1);
		end
		if (cmd.div_step) begin
			// The column is what is left once the row times the width is taken away.
			rem_q <= XW'(32'(addr_q) - 32'(quo_q) * SCREEN_WIDTH);
		end
	end

	assign next_pc        = pc_q;
	assign index_value    = i_q;
	assign pixel_value    = pix_q;
	assign screen_changed = chg_q;
	assign collision      = col_q;
	assign sound_on       = (st_q != 8'h00);
	assign unhandled      = bad_q;

`ifndef SYNTH
	// A push never happens on a full stack and a pop never on an empty one.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (lvl_q < STK_FULL))
		else $error("stack push while full");
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (lvl_q != '0))
		else $error("stack pop while empty");
	// Clearing the screen and writing a sprite row never coincide.
	a_cls_drw: assert property (@(posedge clk) disable iff (!arst_n)
		!(cls && cmd.drw_wr))
		else $error("clear and draw in the same cycle");
`endif

endmodule

FILE: verif/chip8_instruction_execute_unit_test.sv
// Self-checking testbench for chip8_instruction_execute_unit: directed and random requests,
// with every result checked against an in-bench predictor of the CHIP-8 machine state.
// Depends on c8x_pkg and the chip8_instruction_execute_unit RTL only.
module chip8_instruction_execute_unit_test;

	localparam int PIXELS   = 64 * 32;
	localparam int WD_LIMIT = 3000;

	typedef struct {
		logic [11:0] pc;
		logic [11:0] idx;
		logic        pix;
		logic        changed;
		logic        coll;
		logic        snd;
		logic        bad;
	} chip8_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = c8x_pkg::FN_EXEC;
	logic [15:0] instruction = '0;
	logic [11:0] mem_addr = '0;
	logic [7:0]  mem_data = '0;
	logic [7:0]  random_byte = '0;
	logic        done;
	logic [11:0] next_pc;
	logic [11:0] index_value;
	logic        pixel_value;
	logic        screen_changed;
	logic        collision;
	logic        sound_on;
	logic        unhandled;

	// Machine state as the predictor sees it.
	logic [7:0]  vreg [16];
	logic [11:0] ireg;
	logic [11:0] pc;
	logic [11:0] call_stack [16];
	int          depth;
	logic [7:0]  dt;
	logic [7:0]  st;
	logic [7:0]  ram [4096];
	bit          ram_written [4096];
	bit          frame [PIXELS];

	chip8_result_t pending_results [$];
	int errors = 0;
	int requests = 0;
	int results_seen = 0;
	int draws = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	chip8_instruction_execute_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.instruction(instruction), .mem_addr(mem_addr), .mem_data(mem_data),
		.random_byte(random_byte), .done(done), .next_pc(next_pc),
		.index_value(index_value), .pixel_value(pixel_value),
		.screen_changed(screen_changed), .collision(collision),
		.sound_on(sound_on), .unhandled(unhandled)
	);

	always #1 clk = ~clk;

	function automatic chip8_result_t execute_request(logic [1:0] f, logic [15:0] op,
			logic [11:0] a, logic [7:0] d, logic [7:0] rnd);
		chip8_result_t r;
		logic [3:0] x, y, n;
		logic [7:0] kk, vx, vy, bits;
		logic [8:0] sum;
		int px, py, k;
		r = '{default: 1'b0};
		x = op[11:8];
		y = op[7:4];
		n = op[3:0];
		kk = op[7:0];
		vx = vreg[x];
		vy = vreg[y];
		case (f)
			c8x_pkg::FN_MEMW: begin
				ram[a] = d;
				ram_written[a] = 1'b1;
			end
			c8x_pkg::FN_TICK: begin
				if (dt != 0) dt--;
				if (st != 0) st--;
			end
			c8x_pkg::FN_PIX: if (a < PIXELS) r.pix = frame[a];
			default: begin
				pc = pc + 12'd2;
				case (op[15:12])
					c8x_pkg::OP_SYS: begin
						if (op == c8x_pkg::OP_CLS) begin
							foreach (frame[i]) frame[i] = 1'b0;
							r.changed = 1'b1;
						end else if (op == c8x_pkg::OP_RET) begin
							if (depth == 0) r.bad = 1'b1;
							else begin
								depth--;
								pc = call_stack[depth];
							end
						end else r.bad = 1'b1;
					end
					c8x_pkg::OP_JP: pc = op[11:0];
					c8x_pkg::OP_CALL: begin
						if (depth >= 16) r.bad = 1'b1;
						else begin
							call_stack[depth] = pc;
							depth++;
							pc = op[11:0];
						end
					end
					c8x_pkg::OP_SEK: if (vx == kk) pc = pc + 12'd2;
					c8x_pkg::OP_SNEK: if (vx != kk) pc = pc + 12'd2;
					c8x_pkg::OP_SER: if (n != 0) r.bad = 1'b1; else if (vx == vy) pc = pc + 12'd2;
					c8x_pkg::OP_LDK: vreg[x] = kk;
					c8x_pkg::OP_ADDK: vreg[x] = vx + kk;
					c8x_pkg::OP_ALU: begin
						case (n)
							c8x_pkg::ALU_LD: vreg[x] = vy;
							c8x_pkg::ALU_OR: vreg[x] = vx | vy;
							c8x_pkg::ALU_AND: vreg[x] = vx & vy;
							c8x_pkg::ALU_XOR: vreg[x] = vx ^ vy;
							c8x_pkg::ALU_ADD: begin
								sum = {1'b0, vx} + {1'b0, vy};
								vreg[x] = sum[7:0];
								vreg[c8x_pkg::REG_VF] = {7'd0, sum[8]};
							end
							c8x_pkg::ALU_SUB: begin
								vreg[x] = vx - vy;
								vreg[c8x_pkg::REG_VF] = {7'd0, vx >= vy};
							end
							c8x_pkg::ALU_SHR: begin
								vreg[x] = vx >> 1;
								vreg[c8x_pkg::REG_VF] = {7'd0, vx[0]};
							end
							default: r.bad = 1'b1;
						endcase
					end
					c8x_pkg::OP_SNER: if (n != 0) r.bad = 1'b1; else if (vx != vy) pc = pc + 12'd2;
					c8x_pkg::OP_LDI: ireg = op[11:0];
					c8x_pkg::OP_JPV0: pc = op[11:0] + {4'd0, vreg[0]};
					c8x_pkg::OP_RND: vreg[x] = rnd & kk;
					c8x_pkg::OP_DRW: begin
						for (int row = 0; row < n; row++) begin
							bits = ram[12'(ireg + row)];
							py = (int'(vy) + row) % 32;
							for (int col = 0; col < 8; col++) begin
								if (bits[7 - col]) begin
									px = (int'(vx) + col) % 64;
									k = py * 64 + px;
									if (frame[k]) r.coll = 1'b1;
									frame[k] = ~frame[k];
								end
							end
						end
						vreg[c8x_pkg::REG_VF] = {7'd0, r.coll};
						r.changed = 1'b1;
					end
					c8x_pkg::OP_MISC: begin
						if (kk == c8x_pkg::MI_LD_VDT) vreg[x] = dt;
						else if (kk == c8x_pkg::MI_LD_DT) dt = vx;
						else if (kk == c8x_pkg::MI_LD_ST) st = vx;
						else if (kk == c8x_pkg::MI_ADD_I) ireg = ireg + {4'd0, vx};
						else r.bad = 1'b1;
					end
					default: r.bad = 1'b1;
				endcase
			end
		endcase
		r.pc = pc;
		r.idx = ireg;
		r.snd = (st != 0);
		return r;
	endfunction

	task automatic send_request(logic [1:0] f, logic [15:0] op, logic [11:0] a,
			logic [7:0] d, logic [7:0] rnd);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		instruction <= op;
		mem_addr <= a;
		mem_data <= d;
		random_byte <= rnd;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(execute_request(f, op, a, d, rnd));
		requests++;
	endtask

	task automatic run_op(logic [15:0] op);
		send_request(c8x_pkg::FN_EXEC, op, 12'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// A draw must only fetch sprite bytes that have been loaded, so fill any gaps first.
	task automatic draw_sprite_rows(logic [3:0] x, logic [3:0] y, logic [3:0] n);
		logic [11:0] a;
		for (int row = 0; row < n; row++) begin
			a = 12'(ireg + row);
			if (!ram_written[a])
				send_request(c8x_pkg::FN_MEMW, 16'($urandom), a, 8'($urandom), 8'($urandom));
		end
		run_op({c8x_pkg::OP_DRW, x, y, n});
		draws++;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	always @(posedge clk) begin
		chip8_result_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("result %0d arrived with no request outstanding", results_seen);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (next_pc !== e.pc) report_mismatch("next_pc", next_pc, e.pc);
				if (index_value !== e.idx) report_mismatch("index_value", index_value, e.idx);
				if (pixel_value !== e.pix) report_mismatch("pixel_value", pixel_value, e.pix);
				if (screen_changed !== e.changed)
					report_mismatch("screen_changed", screen_changed, e.changed);
				if (collision !== e.coll) report_mismatch("collision", collision, e.coll);
				if (sound_on !== e.snd) report_mismatch("sound_on", sound_on, e.snd);
				if (unhandled !== e.bad) report_mismatch("unhandled", unhandled, e.bad);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("chip8_instruction_execute_unit_test: FAIL");
			$finish;
		end
	end

	task automatic test_reset_state();
		send_request(c8x_pkg::FN_PIX, '0, 12'd0, '0, '0);
		send_request(c8x_pkg::FN_PIX, '0, 12'd2047, '0, '0);
		send_request(c8x_pkg::FN_PIX, '0, 12'hFFF, '0, '0);
		send_request(c8x_pkg::FN_TICK, '0, '0, '0, '0);
		run_op(c8x_pkg::OP_RET);
	endtask

	task automatic test_alu_flags();
		run_op({c8x_pkg::OP_LDK, 4'h1, 8'hFF});
		run_op({c8x_pkg::OP_LDK, 4'h2, 8'h01});
		run_op({c8x_pkg::OP_ALU, 4'h1, 4'h2, c8x_pkg::ALU_ADD});
		run_op({c8x_pkg::OP_ALU, 4'h2, 4'h1, c8x_pkg::ALU_SUB});
		run_op({c8x_pkg::OP_ALU, 4'h1, 4'h2, c8x_pkg::ALU_SUB});
		run_op({c8x_pkg::OP_ALU, 4'h2, 4'h2, c8x_pkg::ALU_SHR});
		run_op({c8x_pkg::OP_ALU, 4'hF, 4'h2, c8x_pkg::ALU_ADD});
		run_op({c8x_pkg::OP_ALU, 4'h1, 4'h2, 4'h7});
		run_op({c8x_pkg::OP_RND, 4'h3, 8'hFF});
		run_op({c8x_pkg::OP_MISC, 4'h1, 8'h65});
		run_op(16'h0123);
		run_op({c8x_pkg::OP_SER, 4'h1, 4'h2, 4'h1});
	endtask

	task automatic test_call_stack();
		for (int i = 0; i < 17; i++) run_op({c8x_pkg::OP_CALL, 12'($urandom)});
		for (int i = 0; i < 17; i++) run_op(c8x_pkg::OP_RET);
		run_op({c8x_pkg::OP_JPV0, 12'hFFF});
		run_op({c8x_pkg::OP_JP, 12'hFFE});
		run_op({c8x_pkg::OP_SEK, 4'h0, 8'h00});
	endtask

	task automatic test_draw_wrap();
		run_op({c8x_pkg::OP_LDI, 12'hFFE});
		run_op({c8x_pkg::OP_LDK, 4'h4, 8'd62});
		run_op({c8x_pkg::OP_LDK, 4'h5, 8'd31});
		draw_sprite_rows(4'h4, 4'h5, 4'hF);
		draw_sprite_rows(4'h4, 4'h5, 4'hF);
		draw_sprite_rows(4'h4, 4'h5, 4'h0);
		send_request(c8x_pkg::FN_PIX, '0, 12'd2047, '0, '0);
		run_op(c8x_pkg::OP_CLS);
	endtask

	task automatic test_timers();
		run_op({c8x_pkg::OP_LDK, 4'h6, 8'h02});
		run_op({c8x_pkg::OP_MISC, 4'h6, c8x_pkg::MI_LD_DT});
		run_op({c8x_pkg::OP_MISC, 4'h6, c8x_pkg::MI_LD_ST});
		repeat (3) send_request(c8x_pkg::FN_TICK, '0, '0, '0, '0);
		run_op({c8x_pkg::OP_MISC, 4'h7, c8x_pkg::MI_LD_VDT});
		run_op({c8x_pkg::OP_MISC, 4'h6, c8x_pkg::MI_ADD_I});
	endtask

	task automatic test_random_mix(int count, int pct);
		int pick;
		logic [3:0] x, y;
		logic [15:0] op;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			x = 4'($urandom);
			y = 4'($urandom);
			op = 16'($urandom);
			if (pick < 6) send_request(c8x_pkg::FN_MEMW, 16'($urandom), 12'($urandom),
				8'($urandom), 8'($urandom));
			else if (pick < 11) send_request(c8x_pkg::FN_TICK, 16'($urandom), 12'($urandom),
				8'($urandom), 8'($urandom));
			else if (pick < 20) send_request(c8x_pkg::FN_PIX, 16'($urandom), 12'($urandom),
				8'($urandom), 8'($urandom));
			else if (pick < 32) draw_sprite_rows(x, y, ($urandom_range(9) == 0) ?
				4'($urandom) : 4'($urandom_range(0, 4)));
			else if (pick < 34) run_op(c8x_pkg::OP_CLS);
			else if (pick < 38) run_op(c8x_pkg::OP_RET);
			else if (pick < 42) run_op({c8x_pkg::OP_CALL, 12'($urandom)});
			else if (pick < 52) run_op({c8x_pkg::OP_ALU, x, y, 4'($urandom_range(0, 6))});
			else if (pick < 58) run_op({c8x_pkg::OP_MISC, x,
				($urandom_range(1)) ? c8x_pkg::MI_LD_DT : c8x_pkg::MI_LD_ST});
			else if (pick < 62) run_op({c8x_pkg::OP_MISC, x,
				($urandom_range(1)) ? c8x_pkg::MI_LD_VDT : c8x_pkg::MI_ADD_I});
			else if (pick < 70) run_op({c8x_pkg::OP_SEK + 4'($urandom_range(1)), x, vreg[x] ^
				8'($urandom_range(1))});
			else if (op[15:12] == c8x_pkg::OP_DRW) draw_sprite_rows(op[11:8], op[7:4], op[3:0]);
			else run_op(op);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		pc = c8x_pkg::PC_RESET;
		ireg = '0;
		depth = 0;
		dt = '0;
		st = '0;
		foreach (vreg[i]) vreg[i] = '0;
		foreach (frame[i]) frame[i] = 1'b0;
		foreach (ram_written[i]) ram_written[i] = 1'b0;
		test_reset_state();
		test_alu_flags();
		test_call_stack();
		test_draw_wrap();
		test_timers();
		test_random_mix(250, 10);
		test_random_mix(250, 74);
		test_random_mix(250, 0);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d requests (%0d draws), %0d results checked", requests, draws,
			results_seen);
		$display("directed flags, stack limits, wrapped sprites and timers, then random mix");
		if (errors == 0 && pending_results.size() == 0)
			$display("chip8_instruction_execute_unit_test: PASS");
		else
			$display("chip8_instruction_execute_unit_test: FAIL");
		$finish;
	end

endmodule
